// ===== hdl/kwsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsd_pkg: shared types and functions for the keyed word stream descrambler
// Request and response payloads, register codes, the configuration set and
// the bit-level key functions used by the transform.
// ----------------------------------------------------------------------------
package kwsd_pkg;

   localparam int IndexWidth = 3;
   localparam int DataWidth  = 32;

   localparam logic [IndexWidth-1:0] REG_SEED_ONE     = 3'd0;
   localparam logic [IndexWidth-1:0] REG_SEED_TWO     = 3'd1;
   localparam logic [IndexWidth-1:0] REG_SEED_THREE   = 3'd2;
   localparam logic [IndexWidth-1:0] REG_SIMPLE_MODE  = 3'd3;
   localparam logic [IndexWidth-1:0] REG_WINDOW_START = 3'd4;
   localparam logic [IndexWidth-1:0] REG_WINDOW_END   = 3'd5;

   localparam logic CMD_WORD    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [15:0] EVEN_MASK   = 16'h5555;
   localparam logic [15:0] ODD_MASK    = 16'hAAAA;
   localparam logic [15:0] DERIVE_KEEP = 16'h9E79;
   localparam logic [15:0] HOLD_MASK   = 16'h8000;
   localparam logic [15:0] SHIFT_MASK  = 16'h3FFF;
   localparam logic [32:0] POS_MAX     = 33'h0_FFFF_FFFF;

   typedef struct packed {
      logic        command;
      logic [15:0] scrambled_word;
   } req_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       run_last;
      logic       stream_last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] seed_one;
      logic [15:0] seed_two;
      logic [15:0] seed_three;
      logic        simple_mode;
      logic [31:0] window_start;
      logic [31:0] window_end;
   } cfg_type;

   // Result of one step: how many bytes the word yields and the plain word
   typedef struct packed {
      logic [1:0]  byte_count;
      logic [15:0] word;
   } step_type;

   function automatic logic [15:0] pair_mix(input logic [15:0] w, input logic [15:0] k);
      logic [15:0] sw;
      logic [15:0] odd;
      logic [15:0] sel;
      sw  = ((w & EVEN_MASK) << 1) | ((w >> 1) & EVEN_MASK);
      odd = k & ODD_MASK;
      sel = odd | (odd >> 1);
      return ((sw & sel) | (w & ~sel)) ^ (k & EVEN_MASK);
   endfunction

   // Exchange bits 13/14, 7/8 and 1/2
   function automatic logic [15:0] exchange_key_bits(input logic [15:0] v);
      logic [15:0] r;
      r     = v & DERIVE_KEEP;
      r[14] = v[13];
      r[13] = v[14];
      r[8]  = v[7];
      r[7]  = v[8];
      r[2]  = v[1];
      r[1]  = v[2];
      return r;
   endfunction

   function automatic logic [15:0] spread_key(input logic [7:0] b);
      logic [15:0] r;
      r[14] = b[0];  r[1] = b[0];
      r[12] = b[1];  r[3] = b[1];
      r[10] = b[2];  r[5] = b[2];
      r[8]  = b[3];  r[7] = b[3];
      r[9]  = b[4];  r[6] = b[4];
      r[11] = b[5];  r[4] = b[5];
      r[13] = b[6];  r[2] = b[6];
      r[15] = b[7];  r[0] = b[7];
      return r;
   endfunction

endpackage

// ===== hdl/kwsd_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsd_csr: configuration register file
// Holds seeds, mode and window bounds; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module kwsd_csr
   import kwsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SEED_ONE:     cfg_in.seed_one     = csr_data[15:0];
            REG_SEED_TWO:     cfg_in.seed_two     = csr_data[15:0];
            REG_SEED_THREE:   cfg_in.seed_three   = csr_data[15:0];
            REG_SIMPLE_MODE:  cfg_in.simple_mode  = csr_data[0];
            REG_WINDOW_START: cfg_in.window_start = csr_data;
            REG_WINDOW_END:   cfg_in.window_end   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/kwsd_key_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsd_key_step: key state and word transform
// Descrambles one request per step; words in window advance keys and position.
// ----------------------------------------------------------------------------
module kwsd_key_step
   import kwsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     step_en,
   input  req_type  item,
   output step_type step
);

   logic [15:0] key_one_ff, key_one_in;
   logic [15:0] key_two_ff, key_two_in;
   logic [7:0]  key_three_ff, key_three_in;
   logic [31:0] position_ff, position_in;

   logic        in_window;
   logic [32:0] next_pos;
   logic        last_word;
   logic [15:0] plain;

   assign in_window = position_ff < cfg.window_end;
   assign next_pos  = {1'b0, position_ff} + 33'd2;
   assign last_word = next_pos >= {1'b0, cfg.window_end};

   always_comb begin
      if (cfg.simple_mode) begin
         plain = pair_mix(item.scrambled_word, key_one_ff);
      end else begin
         plain = pair_mix(item.scrambled_word, exchange_key_bits(key_one_ff ^ key_two_ff))
               ^ spread_key(key_three_ff);
      end
   end

   always_comb begin
      key_one_in   = key_one_ff;
      key_two_in   = key_two_ff;
      key_three_in = key_three_ff;
      position_in  = position_ff;
      step.word       = plain;
      step.byte_count = 2'd0;
      if (step_en) begin
         if (item.command == CMD_RESTART) begin
            key_one_in   = cfg.seed_one;
            key_two_in   = cfg.seed_two;
            key_three_in = cfg.seed_three[7:0];
            position_in  = cfg.window_start;
         end else if (in_window) begin
            step.byte_count = last_word ? 2'd1 : 2'd2;
            position_in     = (next_pos > POS_MAX) ? POS_MAX[31:0] : next_pos[31:0];
            if (cfg.simple_mode) begin
               key_one_in = {key_one_ff[14:0], key_one_ff[15]};
            end else begin
               if (key_one_ff[14] ^ key_one_ff[15]) begin
                  key_two_in = {key_two_ff[14:0], key_two_ff[15]};
               end
               // Hold bit 15, rotate bits 14..0
               key_one_in   = (key_one_ff & HOLD_MASK) | ((key_one_ff & SHIFT_MASK) << 1)
                            | {15'd0, key_one_ff[14]};
               key_three_in = key_three_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_ff   <= '0;
         key_two_ff   <= '0;
         key_three_ff <= '0;
         position_ff  <= '0;
      end else begin
         key_one_ff   <= key_one_in;
         key_two_ff   <= key_two_in;
         key_three_ff <= key_three_in;
         position_ff  <= position_in;
      end
   end

endmodule

// ===== hdl/kwsd_rsp_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsd_rsp_buf: two-entry response buffer
// Holds the high and low byte of one word and hands them out in order.
// ----------------------------------------------------------------------------
module kwsd_rsp_buf
   import kwsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  step_type step,
   output logic     free,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       rsp_fire;
   logic       last_only;

   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = head_ff;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign free      = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_fire);
   assign last_only = step.byte_count == 2'd1;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (load) begin
         head_in  = '{plain_byte: step.word[15:8], run_last: last_only, stream_last: last_only};
         tail_in  = '{plain_byte: step.word[7:0], run_last: 1'b1, stream_last: 1'b0};
         count_in = step.byte_count;
      end else if (rsp_fire) begin
         // advance to the low byte
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ===== hdl/keyed_word_stream_descrambler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_word_stream_descrambler_core: keyed word stream descrambler
// Turns scrambled 16-bit words into descrambled bytes, high byte first.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : register writes (seeds, mode, window); csr_ready is always high.
//            Write only while the block is idle. Seeds and window start take
//            effect on the next restart; mode and window end are read per word.
//   req_*  : one request per word, or a restart command (no output).
//   rsp_*  : descrambled bytes; run_last marks the final byte of a word,
//            stream_last the final byte of the window.
// Flow: a request is held in the input register and transformed into the
//   response buffer once the buffer is free; the buffer drives rsp_* from
//   its registered head byte.
// Throughput: a two-byte word holds the buffer until both bytes are taken on the
//   byte-wide response port; restarts and words past the window end retire
//   at one per cycle while the buffer is free.
// Reset: clears configuration, keys, position and valid state; the window is empty.
// Stall: a stalled response holds; the input register fills and then
//   req_stall rises until the buffer frees.
// ----------------------------------------------------------------------------
module keyed_word_stream_descrambler_core
   import kwsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_data
);

   cfg_type  cfg;
   step_type step;
   req_type  item_ff;
   logic     item_valid_ff, item_valid_in;
   logic     buf_free;
   logic     advance;
   logic     req_fire;

   assign advance   = item_valid_ff && buf_free;
   assign req_stall = item_valid_ff && !buf_free;
   assign req_fire  = req_valid && !req_stall;

   kwsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kwsd_key_step u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (item_ff),
      .step    (step)
   );

   kwsd_rsp_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .step      (step),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_fire) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
   end

`ifndef NO_ASSERTIONS
   // a high byte that is not the last of its word is always followed by the low byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_last |=> rsp_valid)
      else $error("low byte missing after high byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_last |-> rsp_data.run_last)
      else $error("stream_last without run_last");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff && rsp_valid)
      else $error("stall with empty input register or empty buffer");
`endif

endmodule
